/* hdl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FTE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("implication check failed");
`define FTE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define FTE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define FTE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

/* hdl/fte_pkg.sv */
// Types, constants and arithmetic helpers of the folded escape-time block.
`default_nettype none
package fte_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 24;
  localparam int ITER_W  = 16;
  localparam int NORM_W  = 32;
  localparam int ACC_W   = 34;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_FOLD_FROM   = 3'd0,
    REG_FOLD_TO     = 3'd1,
    REG_JULIA_EN    = 3'd2,
    REG_JULIA_CX    = 3'd3,
    REG_JULIA_CY    = 3'd4,
    REG_JULIA_CZ    = 3'd5,
    REG_ESC_RADIUS  = 3'd6,
    REG_MAX_ITER    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
  } in_word_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations_done;
    logic [NORM_W-1:0] escape_norm_sq;
    logic              escaped;
  } out_word_t;

  typedef struct packed {
    logic [3:0]                fold_from;
    logic [3:0]                fold_to;
    logic                      julia_enable;
    logic signed [COORD_W-1:0] julia_cx;
    logic signed [COORD_W-1:0] julia_cy;
    logic signed [COORD_W-1:0] julia_cz;
    logic [NORM_W-1:0]         esc_radius_sq;
    logic [ITER_W-1:0]         max_iterations;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MX, S_MY, S_MZ, S_MP1, S_MP2,
    S_RA, S_RAABS, S_RB, S_RBABS, S_RS, S_RX, S_NX,
    S_Q1, S_N1, S_NY, S_Q2, S_N2, S_NZ,
    S_SX, S_SY, S_SZ, S_SA, S_CHK, S_OUT
  } state_t;

  // {overflow, sum} of a checked add or subtract
  function automatic logic [COORD_W:0] add_chk(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b,
                                               input logic sub);
    logic [COORD_W:0] s;
    s = sub ? ({a[COORD_W-1], a} - {b[COORD_W-1], b})
            : ({a[COORD_W-1], a} + {b[COORD_W-1], b});
    return {s[COORD_W] ^ s[COORD_W-1], s[COORD_W-1:0]};
  endfunction

  // {overflow, value} of an optional absolute value
  function automatic logic [COORD_W:0] abs_opt(input logic signed [COORD_W-1:0] a,
                                               input logic en);
    logic [COORD_W-1:0] v;
    v = (en && a[COORD_W-1]) ? (~a + 1'b1) : a;
    return {en && (a == COORD_MIN), v};
  endfunction

endpackage
`default_nettype wire

/* hdl/fte_cfg.sv */
// Register file behind the APB-style configuration port.
`default_nettype none
module fte_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [fte_pkg::ADDR_W-1:0] paddr,
  input  wire logic [fte_pkg::DATA_W-1:0] pwdata,
  output logic      [fte_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output fte_pkg::cfg_t                  cfg
);
  import fte_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fold_from      <= 4'd0;
      cfg_r.fold_to        <= 4'd0;
      cfg_r.julia_enable   <= 1'b0;
      cfg_r.julia_cx       <= '0;
      cfg_r.julia_cy       <= '0;
      cfg_r.julia_cz       <= '0;
      cfg_r.esc_radius_sq  <= NORM_W'(67108864);
      cfg_r.max_iterations <= ITER_W'(256);
    end else if (wr_en) begin
      case (idx)
        REG_FOLD_FROM:  cfg_r.fold_from      <= pwdata[3:0];
        REG_FOLD_TO:    cfg_r.fold_to        <= pwdata[3:0];
        REG_JULIA_EN:   cfg_r.julia_enable   <= pwdata[0];
        REG_JULIA_CX:   cfg_r.julia_cx       <= pwdata[COORD_W-1:0];
        REG_JULIA_CY:   cfg_r.julia_cy       <= pwdata[COORD_W-1:0];
        REG_JULIA_CZ:   cfg_r.julia_cz       <= pwdata[COORD_W-1:0];
        REG_ESC_RADIUS: cfg_r.esc_radius_sq  <= pwdata[NORM_W-1:0];
        REG_MAX_ITER:   cfg_r.max_iterations <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FOLD_FROM:  prdata = {28'd0, cfg_r.fold_from};
      REG_FOLD_TO:    prdata = {28'd0, cfg_r.fold_to};
      REG_JULIA_EN:   prdata = {31'd0, cfg_r.julia_enable};
      REG_JULIA_CX:   prdata = cfg_r.julia_cx;
      REG_JULIA_CY:   prdata = cfg_r.julia_cy;
      REG_JULIA_CZ:   prdata = cfg_r.julia_cz;
      REG_ESC_RADIUS: prdata = cfg_r.esc_radius_sq;
      REG_MAX_ITER:   prdata = {16'd0, cfg_r.max_iterations};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/fte_mul.sv */
// Shared fixed-point multiplier with registered product and range flag.
`default_nettype none
module fte_mul (
  input  wire logic                              clk,
  input  wire logic signed [fte_pkg::COORD_W-1:0] a,
  input  wire logic signed [fte_pkg::COORD_W-1:0] b,
  output logic signed      [fte_pkg::COORD_W-1:0] prod_r,
  output logic                                   ovf_r
);
  import fte_pkg::*;

  logic signed [2*COORD_W-1:0] full;
  logic [2*COORD_W-1-(FRAC_W+COORD_W-1):0] top;

  assign full = a * b;
  assign top  = full[2*COORD_W-1:FRAC_W+COORD_W-1];

  always_ff @(posedge clk) begin
    prod_r <= full[FRAC_W+COORD_W-1:FRAC_W];
    ovf_r  <= !((&top) || !(|top));
  end

endmodule
`default_nettype wire

/* hdl/fte_core.sv */
// Iteration sequencer around the shared multiplier and adder.
`default_nettype none
module fte_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fte_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fte_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fte_pkg::out_word_t      out_data
);
  import fte_pkg::*;

  state_t state_r, state_nxt;
  logic signed [COORD_W-1:0] x_r, y_r, z_r, cx_r, cy_r, cz_r;
  logic signed [COORD_W-1:0] x_nxt, y_nxt, z_nxt, cx_nxt, cy_nxt, cz_nxt;
  logic signed [COORD_W-1:0] x2_r, y2_r, z2_r, p1_r, p2_r, ra_r, rb_r;
  logic signed [COORD_W-1:0] x2_nxt, y2_nxt, z2_nxt, p1_nxt, p2_nxt, ra_nxt, rb_nxt;
  logic signed [COORD_W-1:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt, limit_r, limit_nxt;
  out_word_t         out_r, out_nxt;

  logic signed [COORD_W-1:0] mul_a, mul_b, prod;
  logic                      mul_ovf;
  logic signed [COORD_W-1:0] alu_a, alu_b;
  logic                      alu_sub;
  logic [COORD_W:0]          alu_res, abs_a, abs_b;
  logic [COORD_W-1:0]        alu_sum;
  logic                      alu_ovf;
  logic [ACC_W-1:0]          prod_ext;

  fte_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod),
    .ovf_r  (mul_ovf)
  );

  assign alu_res  = add_chk(alu_a, alu_b, alu_sub);
  assign alu_sum  = alu_res[COORD_W-1:0];
  assign alu_ovf  = alu_res[COORD_W];
  assign prod_ext = {{(ACC_W-COORD_W){1'b0}}, prod};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;  y_r <= y_nxt;  z_r <= z_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    x2_r <= x2_nxt; y2_r <= y2_nxt; z2_r <= z2_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; ra_r <= ra_nxt; rb_r <= rb_nxt;
    nx_r <= nx_nxt; ny_r <= ny_nxt; nz_r <= nz_nxt;
    acc_r <= acc_nxt; ovf_r <= ovf_nxt;
    iter_r <= iter_nxt; limit_r <= limit_nxt;
    out_r <= out_nxt;
  end

  // operand select for the shared units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    abs_a   = abs_opt(x_r, 1'b0);
    abs_b   = abs_opt(y_r, 1'b0);
    case (state_r)
      S_MX:    begin mul_a = x_r; mul_b = x_r; end
      S_MY:    begin mul_a = y_r; mul_b = y_r; end
      S_MZ:    begin mul_a = z_r; mul_b = z_r; end
      S_MP1: begin
        abs_a = abs_opt(x_r, cfg.fold_from[1]);
        abs_b = abs_opt(y_r, cfg.fold_from[2]);
        mul_a = abs_a[COORD_W-1:0];
        mul_b = abs_b[COORD_W-1:0];
      end
      S_MP2: begin
        abs_a = abs_opt(x_r, cfg.fold_to[1]);
        abs_b = abs_opt(z_r, cfg.fold_to[2]);
        mul_a = abs_a[COORD_W-1:0];
        mul_b = abs_b[COORD_W-1:0];
      end
      S_RA:    begin alu_a = x2_r; alu_b = y2_r; alu_sub = 1'b1; end
      S_RAABS: begin alu_b = ra_r; alu_sub = 1'b1; end
      S_RB:    begin alu_a = x2_r; alu_b = z2_r; alu_sub = 1'b1; end
      S_RBABS: begin alu_b = rb_r; alu_sub = 1'b1; end
      S_RS:    begin alu_a = ra_r; alu_b = rb_r; end
      S_RX:    begin alu_a = ra_r; alu_b = x2_r; alu_sub = 1'b1; end
      S_NX:    begin alu_a = ra_r; alu_b = cx_r; end
      S_Q1:    begin alu_a = p1_r; alu_b = p1_r; end
      S_N1:    begin alu_b = p1_r; alu_sub = 1'b1; end
      S_NY:    begin alu_a = p1_r; alu_b = cy_r; end
      S_Q2:    begin alu_a = p2_r; alu_b = p2_r; end
      S_N2:    begin alu_b = p2_r; alu_sub = 1'b1; end
      S_NZ:    begin alu_a = p2_r; alu_b = cz_r; end
      S_SX:    begin mul_a = nx_r; mul_b = nx_r; end
      S_SY:    begin mul_a = ny_r; mul_b = ny_r; end
      S_SZ:    begin mul_a = nz_r; mul_b = nz_r; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;  y_nxt = y_r;  z_nxt = z_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    x2_nxt = x2_r; y2_nxt = y2_r; z2_nxt = z2_r;
    p1_nxt = p1_r; p2_nxt = p2_r; ra_nxt = ra_r; rb_nxt = rb_r;
    nx_nxt = nx_r; ny_nxt = ny_r; nz_nxt = nz_r;
    acc_nxt = acc_r; ovf_nxt = ovf_r;
    iter_nxt = iter_r; limit_nxt = limit_r;
    out_nxt = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt  = in_data.start_x;
          y_nxt  = in_data.start_y;
          z_nxt  = in_data.start_z;
          cx_nxt = cfg.julia_enable ? cfg.julia_cx : in_data.start_x;
          cy_nxt = cfg.julia_enable ? cfg.julia_cy : in_data.start_y;
          cz_nxt = cfg.julia_enable ? cfg.julia_cz : in_data.start_z;
          limit_nxt = cfg.max_iterations;
          iter_nxt  = '0;
          ovf_nxt   = 1'b0;
          out_nxt   = '0;
          state_nxt = (cfg.max_iterations == '0) ? S_OUT : S_MX;
        end
      end
      S_MX:  state_nxt = S_MY;
      S_MY:  begin x2_nxt = prod; ovf_nxt = ovf_r | mul_ovf; state_nxt = S_MZ; end
      S_MZ:  begin y2_nxt = prod; ovf_nxt = ovf_r | mul_ovf; state_nxt = S_MP1; end
      S_MP1: begin
        z2_nxt = prod;
        ovf_nxt = ovf_r | mul_ovf | abs_a[COORD_W] | abs_b[COORD_W];
        state_nxt = S_MP2;
      end
      S_MP2: begin
        p1_nxt = prod;
        ovf_nxt = ovf_r | mul_ovf | abs_a[COORD_W] | abs_b[COORD_W];
        state_nxt = S_RA;
      end
      S_RA: begin
        p2_nxt = prod;
        ra_nxt = alu_sum;
        ovf_nxt = ovf_r | mul_ovf | alu_ovf;
        state_nxt = S_RAABS;
      end
      S_RAABS: begin
        if (cfg.fold_from[0] && ra_r[COORD_W-1]) begin
          ra_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf;
        end
        state_nxt = S_RB;
      end
      S_RB: begin rb_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_RBABS; end
      S_RBABS: begin
        if (cfg.fold_to[0] && rb_r[COORD_W-1]) begin
          rb_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf;
        end
        state_nxt = S_RS;
      end
      S_RS: begin ra_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_RX; end
      S_RX: begin ra_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_NX; end
      S_NX: begin nx_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_Q1; end
      S_Q1: begin p1_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_N1; end
      S_N1: begin
        if (cfg.fold_from[3]) begin
          p1_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf;
        end
        state_nxt = S_NY;
      end
      S_NY: begin ny_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_Q2; end
      S_Q2: begin p2_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_N2; end
      S_N2: begin
        if (cfg.fold_to[3]) begin
          p2_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf;
        end
        state_nxt = S_NZ;
      end
      S_NZ: begin nz_nxt = alu_sum; ovf_nxt = ovf_r | alu_ovf; state_nxt = S_SX; end
      S_SX: state_nxt = S_SY;
      S_SY: begin acc_nxt = prod_ext; ovf_nxt = ovf_r | mul_ovf; state_nxt = S_SZ; end
      S_SZ: begin
        acc_nxt = acc_r + prod_ext; ovf_nxt = ovf_r | mul_ovf; state_nxt = S_SA;
      end
      S_SA: begin
        acc_nxt = acc_r + prod_ext; ovf_nxt = ovf_r | mul_ovf; state_nxt = S_CHK;
      end
      S_CHK: begin
        if (ovf_r) begin
          out_nxt = '{iterations_done: iter_r, escape_norm_sq: '1, escaped: 1'b1};
          state_nxt = S_OUT;
        end else if (acc_r > {{(ACC_W-NORM_W){1'b0}}, cfg.esc_radius_sq}) begin
          out_nxt.iterations_done = iter_r;
          out_nxt.escape_norm_sq  = (|acc_r[ACC_W-1:NORM_W]) ? '1 : acc_r[NORM_W-1:0];
          out_nxt.escaped         = 1'b1;
          state_nxt = S_OUT;
        end else begin
          x_nxt = nx_r; y_nxt = ny_r; z_nxt = nz_r;
          if (iter_r == limit_r - 1'b1) begin
            out_nxt = '{iterations_done: limit_r, escape_norm_sq: '0, escaped: 1'b0};
            state_nxt = S_OUT;
          end else begin
            iter_nxt  = iter_r + 1'b1;
            state_nxt = S_MX;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/folded_transition_escape_time.sv */
// Top level of the folded transition escape-time block.
//   channel | direction | handshake           | word
//   in_     | input     | in_valid / in_stall | start_x, start_y, start_z
//   out_    | output    | out_valid/out_stall | iterations_done, escape_norm_sq, escaped
//   cfg     | input     | psel/penable/pready | eight registers at 4*i
// One pixel steps through the sequencer states once per iteration of the map, an order
// set by the single shared multiplier and adder stepping through each iteration.
// Synchronous active-low reset puts the sequencer in idle and the registers at defaults.
// in_stall is high from acceptance until the result word is taken; out_stall holds it.
`default_nettype none
`include "assert_macros.svh"
module folded_transition_escape_time (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire fte_pkg::in_word_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output fte_pkg::out_word_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fte_pkg::ADDR_W-1:0] paddr,
  input  wire logic [fte_pkg::DATA_W-1:0] pwdata,
  output logic      [fte_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import fte_pkg::*;

  cfg_t cfg;

  fte_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fte_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `FTE_ASSERT_IMP(a_out_blocks_in, clk, rst_n, out_valid, in_stall)
  `FTE_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `FTE_ASSERT_NXT(a_out_once, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the folded transition escape-time block: scoreboard, drivers and phases.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fte_pkg::*;

  typedef logic signed [127:0] wide_t;

  class escape_board;
    cfg_t      cfg;
    out_word_t want_q[$];
    int        errs;
    int        shown;
    bit        ovf;

    function new();
      cfg = '0;
      cfg.esc_radius_sq = 32'd67108864;
      cfg.max_iterations = 16'd256;
      errs = 0;
      shown = 0;
    endfunction

    function wide_t chk(wide_t v);
      if (v > wide_t'(32'sh7FFFFFFF) || v < -wide_t'(64'sd2147483648)) ovf = 1'b1;
      return v;
    endfunction

    function wide_t absq(wide_t v);
      return chk(v < 0 ? -v : v);
    endfunction

    function wide_t mulq(wide_t a, wide_t b);
      wide_t p;
      p = a * b;
      return chk(p >>> FRAC_W);
    endfunction

    function wide_t imag(wide_t a, wide_t b, logic [3:0] f);
      wide_t q;
      if (f[1]) a = absq(a);
      if (f[2]) b = absq(b);
      q = mulq(a, b);
      q = chk(q + q);
      if (f[3]) q = chk(-q);
      return q;
    endfunction

    function out_word_t escape_of(in_word_t w);
      wide_t x, y, z, cx, cy, cz, x2, y2, z2, ra, rb, nx, ny, nz, n2;
      int unsigned lim, i;
      out_word_t r;
      x = wide_t'(w.start_x);
      y = wide_t'(w.start_y);
      z = wide_t'(w.start_z);
      cx = cfg.julia_enable ? wide_t'(cfg.julia_cx) : x;
      cy = cfg.julia_enable ? wide_t'(cfg.julia_cy) : y;
      cz = cfg.julia_enable ? wide_t'(cfg.julia_cz) : z;
      lim = cfg.max_iterations;
      r.iterations_done = lim[15:0];
      r.escape_norm_sq = '0;
      r.escaped = 1'b0;
      ovf = 1'b0;
      for (i = 0; i < lim; i++) begin
        x2 = mulq(x, x);
        y2 = mulq(y, y);
        z2 = mulq(z, z);
        ra = chk(x2 - y2);
        rb = chk(x2 - z2);
        if (cfg.fold_from[0]) ra = absq(ra);
        if (cfg.fold_to[0]) rb = absq(rb);
        nx = chk(chk(chk(ra + rb) - x2) + cx);
        ny = chk(imag(x, y, cfg.fold_from) + cy);
        nz = chk(imag(x, z, cfg.fold_to) + cz);
        n2 = mulq(nx, nx) + mulq(ny, ny) + mulq(nz, nz);
        if (ovf) begin
          r.iterations_done = i[15:0];
          r.escaped = 1'b1;
          r.escape_norm_sq = '1;
          break;
        end
        if (n2 > wide_t'({1'b0, cfg.esc_radius_sq})) begin
          r.iterations_done = i[15:0];
          r.escaped = 1'b1;
          r.escape_norm_sq = (n2 > wide_t'(33'h0FFFFFFFF)) ? '1 : n2[31:0];
          break;
        end
        x = nx;
        y = ny;
        z = nz;
      end
      return r;
    endfunction

    function void note(in_word_t w);
      want_q.push_back(escape_of(w));
    endfunction

    function void check(out_word_t got);
      out_word_t w;
      if (want_q.size() == 0) begin
        errs++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result word %h", got);
        end
        return;
      end
      w = want_q.pop_front();
      if (got !== w) begin
        errs++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: exp iter %0d norm %h esc %b, got iter %0d norm %h esc %b",
                   w.iterations_done, w.escape_norm_sq, w.escaped,
                   got.iterations_done, got.escape_norm_sq, got.escaped);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  escape_board sb = new();
  bit quiet = 1'b0;
  longint cycles = 0;

  always #1 clk = ~clk;

  folded_transition_escape_time i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("[folded_transition_escape_time] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_cfg(cfg_t c);
    drain();
    cfg_write(REG_FOLD_FROM, 32'(c.fold_from));
    cfg_write(REG_FOLD_TO, 32'(c.fold_to));
    cfg_write(REG_JULIA_EN, 32'(c.julia_enable));
    cfg_write(REG_JULIA_CX, c.julia_cx);
    cfg_write(REG_JULIA_CY, c.julia_cy);
    cfg_write(REG_JULIA_CZ, c.julia_cz);
    cfg_write(REG_ESC_RADIUS, c.esc_radius_sq);
    cfg_write(REG_MAX_ITER, 32'(c.max_iterations));
    sb.cfg = c;
  endtask

  task automatic send(in_word_t w);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note(w);
  endtask

  function automatic logic [31:0] rand_coord();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 50) return 32'($signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000);
    if (k < 80) return 32'($signed($urandom_range(32'h0FFFFFFF)) - 32'sh08000000);
    return $urandom();
  endfunction

  function automatic in_word_t point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w.start_x = x;
    w.start_y = y;
    w.start_z = z;
    return w;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int unsigned k;
    c.fold_from = 4'($urandom());
    c.fold_to = 4'($urandom());
    c.julia_enable = 1'($urandom());
    c.julia_cx = rand_coord();
    c.julia_cy = rand_coord();
    c.julia_cz = rand_coord();
    k = $urandom_range(9);
    c.esc_radius_sq = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFFFFFF :
                      (k < 6) ? 32'd67108864 : $urandom();
    k = $urandom_range(19);
    c.max_iterations = (k == 0) ? 16'd0 : (k == 1) ? 16'd1 : 16'($urandom_range(12, 2));
    return c;
  endfunction

  initial begin
    cfg_t c;
    in_word_t w;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(point(32'h0, 32'h0, 32'h0));
    send(point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send(point(32'h00800000, 32'hFF800000, 32'h00400000));

    c = '0;
    c.fold_from = 4'hF;
    c.fold_to = 4'hF;
    c.esc_radius_sq = 32'hFFFFFFFF;
    c.max_iterations = 16'hFFFF;
    set_cfg(c);
    send(point(32'h80000000, 32'h0, 32'h0));
    send(point(32'h0, 32'h80000000, 32'h80000000));
    send(point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send(point(32'h0B000000, 32'h0, 32'h0));

    c.fold_from = 4'h0;
    c.fold_to = 4'h0;
    c.max_iterations = 16'd0;
    set_cfg(c);
    send(point(32'h7FFFFFFF, 32'h80000000, 32'h12345678));

    c.julia_enable = 1'b1;
    c.julia_cx = 32'h7FFFFFFF;
    c.julia_cy = 32'h80000000;
    c.julia_cz = 32'h80000000;
    c.esc_radius_sq = 32'd0;
    c.max_iterations = 16'd4;
    set_cfg(c);
    send(point(32'h0, 32'h0, 32'h0));
    send(point(32'h00000001, 32'hFFFFFFFF, 32'h0));

    c.julia_cx = 32'h0;
    c.julia_cy = 32'h0;
    c.julia_cz = 32'h0;
    c.fold_from = 4'h9;
    c.fold_to = 4'h6;
    c.max_iterations = 16'd6;
    set_cfg(c);
    send(point(32'h0, 32'h0, 32'h0));
    send(point(32'h00000001, 32'h0, 32'h0));
    send(point(32'hFF000000, 32'h00800000, 32'hFF800000));
    c.esc_radius_sq = 32'd67108864;
    set_cfg(c);
    send(point(32'h00400000, 32'hFFC00000, 32'h00200000));
    send(point(32'hFE000000, 32'h02000000, 32'hFE000000));

    for (int ph = 0; ph < 12; ph++) begin
      set_cfg(rand_cfg());
      quiet = (ph == 4);
      for (int n = 0; n < 100; n++) begin
        w = point(rand_coord(), rand_coord(), rand_coord());
        send(w);
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errs == 0 && sb.want_q.size() == 0) begin
      $display("[folded_transition_escape_time] OK");
    end else begin
      $display("[folded_transition_escape_time] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+hdl
hdl/fte_pkg.sv
hdl/fte_cfg.sv
hdl/fte_mul.sv
hdl/fte_core.sv
hdl/folded_transition_escape_time.sv
tb/tb_top.sv
